@@ sv/fap_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fap_pkg
// shared codes, reset values and control types of the fit and align placement
// ----------------------------------------------------------------------------
package fap_pkg;

  localparam int CFG_IDX_BITS = 3;
  localparam int CENTER_SHIFT = 1;
  localparam int DEST_W_RESET = 80;
  localparam int DEST_H_RESET = 24;

  typedef enum logic [1:0] {
    TUCK_STRETCH = 2'd0,
    TUCK_SHRINK  = 2'd1,
    TUCK_FIT     = 2'd2
  } tuck_t;

  typedef enum logic [1:0] {
    ALIGN_START  = 2'd0,
    ALIGN_CENTER = 2'd1,
    ALIGN_END    = 2'd2
  } align_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TUCK_MODE   = 3'd0,
    CFG_H_ALIGN     = 3'd1,
    CFG_V_ALIGN     = 3'd2,
    CFG_AREA_WIDTH  = 3'd3,
    CFG_AREA_HEIGHT = 3'd4
  } cfg_idx_t;

  localparam tuck_t  TUCK_RESET    = TUCK_FIT;
  localparam align_t H_ALIGN_RESET = ALIGN_START;
  localparam align_t V_ALIGN_RESET = ALIGN_START;

  // scale: aspect scaling applies, err: zero source while scaling,
  // axis_w: width is the limiting axis
  typedef struct packed {
    logic scale;
    logic err;
    logic axis_w;
  } ctl_t;

endpackage
`default_nettype wire

@@ sv/fap_size_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fap_size_if
// source size channel
// ----------------------------------------------------------------------------
interface fap_size_if #(
  parameter int DIM_BITS = 16
) ();
  logic                valid;
  logic                ready;
  logic [DIM_BITS-1:0] source_width;
  logic [DIM_BITS-1:0] source_height;

  modport source (output valid, source_width, source_height, input ready);
  modport sink (input valid, source_width, source_height, output ready);
endinterface
`default_nettype wire

@@ sv/fap_place_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fap_place_if
// placement result channel
// ----------------------------------------------------------------------------
interface fap_place_if #(
  parameter int DIM_BITS = 16
) ();
  logic                valid;
  logic                ready;
  logic [DIM_BITS-1:0] placed_width;
  logic [DIM_BITS-1:0] placed_height;
  logic [DIM_BITS-1:0] offset_x;
  logic [DIM_BITS-1:0] offset_y;
  logic                zero_source_error;

  modport source (
    output valid, placed_width, placed_height, offset_x, offset_y, zero_source_error,
    input  ready
  );
  modport sink (
    input  valid, placed_width, placed_height, offset_x, offset_y, zero_source_error,
    output ready
  );
endinterface
`default_nettype wire

@@ sv/fap_cfg_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fap_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface fap_cfg_if
  import fap_pkg::*;
#(
  parameter int DIM_BITS = 16
) ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [DIM_BITS-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ sv/fap_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fap_cfg_regs
// mode, alignment and destination size registers
// ----------------------------------------------------------------------------
module fap_cfg_regs
  import fap_pkg::*;
#(
  parameter int DIM_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  fap_cfg_if.sink                  cfg,
  output tuck_t                    tuck_mode,
  output align_t                   h_align,
  output align_t                   v_align,
  output logic [DIM_BITS-1:0]      area_width,
  output logic [DIM_BITS-1:0]      area_height
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tuck_mode   <= TUCK_RESET;
      h_align     <= H_ALIGN_RESET;
      v_align     <= V_ALIGN_RESET;
      area_width  <= DIM_BITS'(DEST_W_RESET);
      area_height <= DIM_BITS'(DEST_H_RESET);
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_TUCK_MODE:   tuck_mode   <= tuck_t'(cfg.data[1:0]);
        CFG_H_ALIGN:     h_align     <= align_t'(cfg.data[1:0]);
        CFG_V_ALIGN:     v_align     <= align_t'(cfg.data[1:0]);
        CFG_AREA_WIDTH:  area_width  <= cfg.data;
        CFG_AREA_HEIGHT: area_height <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/fap_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fap_front
// mode decode and cross products, then limiting axis and divider operands
// ----------------------------------------------------------------------------
module fap_front
  import fap_pkg::*;
#(
  parameter int DIM_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [DIM_BITS-1:0] source_width,
  input  wire logic [DIM_BITS-1:0] source_height,
  input  wire tuck_t               tuck_mode,
  input  wire logic [DIM_BITS-1:0] area_width,
  input  wire logic [DIM_BITS-1:0] area_height,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ctl_t                     out_ctl,
  output logic [DIM_BITS-1:0]      out_rem,
  output logic [DIM_BITS-1:0]      out_low,
  output logic [DIM_BITS-1:0]      out_den,
  output logic [DIM_BITS-1:0]      out_w,
  output logic [DIM_BITS-1:0]      out_h
);

  localparam int PROD_BITS = 2 * DIM_BITS;

  // stage 1 registers
  logic                 v1;
  ctl_t                 ctl1;
  logic [DIM_BITS-1:0]  sw1, sh1, w1, h1;
  logic [PROD_BITS-1:0] pa1, pb1;
  logic                 ready1, ready2;

  ctl_t                 ctl1_next;
  logic [DIM_BITS-1:0]  w1_next, h1_next;
  logic                 fits;

  // stage 2 values
  logic                 axis_w;
  logic [PROD_BITS-1:0] num;

  assign ready2   = !out_valid || out_ready;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  always_comb begin
    fits      = (source_width <= area_width) && (source_height <= area_height);
    ctl1_next = '0;
    w1_next   = source_width;
    h1_next   = source_height;
    unique case (tuck_mode)
      TUCK_STRETCH: begin
        w1_next = area_width;
        h1_next = area_height;
      end
      TUCK_SHRINK: begin
        ctl1_next.scale = !fits;
      end
      default: begin
        ctl1_next.scale = 1'b1;
      end
    endcase
    ctl1_next.err = ctl1_next.scale &&
                    ((source_width == '0) || (source_height == '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      ctl1 <= ctl1_next;
      sw1  <= source_width;
      sh1  <= source_height;
      w1   <= w1_next;
      h1   <= h1_next;
      pa1  <= PROD_BITS'(area_width) * PROD_BITS'(source_height);
      pb1  <= PROD_BITS'(area_height) * PROD_BITS'(source_width);
    end
  end

  // width limits on a tie
  assign axis_w = (pa1 <= pb1);
  assign num    = axis_w ? pa1 : pb1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready2) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      out_ctl <= '{scale: ctl1.scale, err: ctl1.err, axis_w: axis_w};
      out_rem <= num[PROD_BITS-1:DIM_BITS];
      out_low <= num[DIM_BITS-1:0];
      out_den <= axis_w ? sw1 : sh1;
      out_w   <= w1;
      out_h   <= h1;
    end
  end

endmodule
`default_nettype wire

@@ sv/fap_div_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fap_div_step
// one restoring division step, one quotient bit shifted into the low word
// ----------------------------------------------------------------------------
module fap_div_step
  import fap_pkg::*;
#(
  parameter int DIM_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ctl_t                in_ctl,
  input  wire logic [DIM_BITS-1:0] in_rem,
  input  wire logic [DIM_BITS-1:0] in_low,
  input  wire logic [DIM_BITS-1:0] in_den,
  input  wire logic [DIM_BITS-1:0] in_w,
  input  wire logic [DIM_BITS-1:0] in_h,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ctl_t                     out_ctl,
  output logic [DIM_BITS-1:0]      out_rem,
  output logic [DIM_BITS-1:0]      out_low,
  output logic [DIM_BITS-1:0]      out_den,
  output logic [DIM_BITS-1:0]      out_w,
  output logic [DIM_BITS-1:0]      out_h
);

  logic [DIM_BITS:0]   trial, diff;
  logic                ge;
  logic [DIM_BITS-1:0] rem_next, low_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    trial    = {in_rem, in_low[DIM_BITS-1]};
    diff     = trial - {1'b0, in_den};
    ge       = (trial >= {1'b0, in_den});
    rem_next = ge ? diff[DIM_BITS-1:0] : trial[DIM_BITS-1:0];
    low_next = {in_low[DIM_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_ctl <= in_ctl;
      out_rem <= rem_next;
      out_low <= low_next;
      out_den <= in_den;
      out_w   <= in_w;
      out_h   <= in_h;
    end
  end

endmodule
`default_nettype wire

@@ sv/fap_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fap_back
// quotient ceiling, clamp to destination, alignment offsets, result register
// ----------------------------------------------------------------------------
module fap_back
  import fap_pkg::*;
#(
  parameter int DIM_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ctl_t                in_ctl,
  input  wire logic [DIM_BITS-1:0] in_rem,
  input  wire logic [DIM_BITS-1:0] in_quo,
  input  wire logic [DIM_BITS-1:0] in_w,
  input  wire logic [DIM_BITS-1:0] in_h,
  input  wire align_t              h_align,
  input  wire align_t              v_align,
  input  wire logic [DIM_BITS-1:0] area_width,
  input  wire logic [DIM_BITS-1:0] area_height,
  fap_place_if.source              place
);

  function automatic logic [DIM_BITS-1:0] align_offset(
    input align_t              align,
    input logic [DIM_BITS-1:0] slack
  );
    logic [DIM_BITS-1:0] off;
    unique case (align)
      ALIGN_CENTER: off = slack >> CENTER_SHIFT;
      ALIGN_END:    off = slack;
      default:      off = '0;
    endcase
    return off;
  endfunction

  logic [DIM_BITS:0]   q_ceil, w_raw, h_raw;
  logic [DIM_BITS-1:0] w_c, h_c;
  logic [DIM_BITS-1:0] w_next, h_next, ox_next, oy_next;

  assign in_ready = !place.valid || place.ready;

  always_comb begin
    q_ceil = {1'b0, in_quo} + (DIM_BITS+1)'(in_rem != '0);
    if (in_ctl.scale) begin
      w_raw = in_ctl.axis_w ? {1'b0, area_width} : q_ceil;
      h_raw = in_ctl.axis_w ? q_ceil : {1'b0, area_height};
    end else begin
      w_raw = {1'b0, in_w};
      h_raw = {1'b0, in_h};
    end
    w_c = (w_raw > {1'b0, area_width})  ? area_width  : w_raw[DIM_BITS-1:0];
    h_c = (h_raw > {1'b0, area_height}) ? area_height : h_raw[DIM_BITS-1:0];
    if (in_ctl.err) begin
      w_next  = '0;
      h_next  = '0;
      ox_next = '0;
      oy_next = '0;
    end else begin
      w_next  = w_c;
      h_next  = h_c;
      ox_next = align_offset(h_align, area_width - w_c);
      oy_next = align_offset(v_align, area_height - h_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      place.valid <= 1'b0;
    end else if (in_ready) begin
      place.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      place.placed_width      <= w_next;
      place.placed_height     <= h_next;
      place.offset_x          <= ox_next;
      place.offset_y          <= oy_next;
      place.zero_source_error <= in_ctl.err;
    end
  end

endmodule
`default_nettype wire

@@ sv/fit_and_align_placement_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fit_and_align_placement_top
// places a source size inside the destination area with fit mode and alignment
//
//   channel  dir  payload                                         handshake
//   size     in   source_width, source_height                     valid/ready
//   place    out  placed_width/height, offset_x/y, zero_src_err   valid/ready
//   cfg      in   index, data (register write)                    valid/ready
//
// one transaction per cycle while the place channel is not stalled; the result
// register is reached through DIM_BITS+3 register stages, set by the
// one-bit-per-stage divider chain of DIM_BITS stages
// reset clears all stage valid bits and loads the register reset values
// each stage holds its contents while the next stage is full and stalled
// ----------------------------------------------------------------------------
module fit_and_align_placement_top
  import fap_pkg::*;
#(
  parameter int DIM_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  fap_size_if.sink  size,
  fap_place_if.source place,
  fap_cfg_if.sink   cfg
);

  tuck_t               tuck_mode;
  align_t              h_align, v_align;
  logic [DIM_BITS-1:0] area_width, area_height;

  logic [DIM_BITS:0]   vld, rdy;
  ctl_t                ctl_s [DIM_BITS+1];
  logic [DIM_BITS-1:0] rem_s [DIM_BITS+1];
  logic [DIM_BITS-1:0] low_s [DIM_BITS+1];
  logic [DIM_BITS-1:0] den_s [DIM_BITS+1];
  logic [DIM_BITS-1:0] w_s   [DIM_BITS+1];
  logic [DIM_BITS-1:0] h_s   [DIM_BITS+1];

  fap_cfg_regs #(.DIM_BITS(DIM_BITS)) u_cfg (
    .clk, .rst, .cfg,
    .tuck_mode, .h_align, .v_align, .area_width, .area_height
  );

  fap_front #(.DIM_BITS(DIM_BITS)) u_front (
    .clk, .rst,
    .in_valid      (size.valid),
    .in_ready      (size.ready),
    .source_width  (size.source_width),
    .source_height (size.source_height),
    .tuck_mode, .area_width, .area_height,
    .out_valid     (vld[0]),
    .out_ready     (rdy[0]),
    .out_ctl       (ctl_s[0]),
    .out_rem       (rem_s[0]),
    .out_low       (low_s[0]),
    .out_den       (den_s[0]),
    .out_w         (w_s[0]),
    .out_h         (h_s[0])
  );

  for (genvar i = 0; i < DIM_BITS; i++) begin : g_div
    fap_div_step #(.DIM_BITS(DIM_BITS)) u_step (
      .clk, .rst,
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_ctl    (ctl_s[i]),
      .in_rem    (rem_s[i]),
      .in_low    (low_s[i]),
      .in_den    (den_s[i]),
      .in_w      (w_s[i]),
      .in_h      (h_s[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_ctl   (ctl_s[i+1]),
      .out_rem   (rem_s[i+1]),
      .out_low   (low_s[i+1]),
      .out_den   (den_s[i+1]),
      .out_w     (w_s[i+1]),
      .out_h     (h_s[i+1])
    );
  end

  fap_back #(.DIM_BITS(DIM_BITS)) u_back (
    .clk, .rst,
    .in_valid (vld[DIM_BITS]),
    .in_ready (rdy[DIM_BITS]),
    .in_ctl   (ctl_s[DIM_BITS]),
    .in_rem   (rem_s[DIM_BITS]),
    .in_quo   (low_s[DIM_BITS]),
    .in_w     (w_s[DIM_BITS]),
    .in_h     (h_s[DIM_BITS]),
    .h_align, .v_align, .area_width, .area_height,
    .place
  );

  // an empty result register lets the whole chain advance
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !place.valid |-> size.ready)
    else $error("size channel stalled with an empty result register");

  a_error_zeroes: assert property (@(posedge clk) disable iff (rst)
    place.valid && place.zero_source_error |->
      place.placed_width == '0 && place.placed_height == '0 &&
      place.offset_x == '0 && place.offset_y == '0)
    else $error("zero source error with nonzero placement");

  a_no_valid_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !place.valid && vld == '0)
    else $error("valid bit survived reset");

endmodule
`default_nettype wire
